### hw/rtl/two_player_game_clock_macros.svh
// Assertion macros used by the game clock checker file.
`ifndef TWO_PLAYER_GAME_CLOCK_MACROS_SVH
`define TWO_PLAYER_GAME_CLOCK_MACROS_SVH

// Property checked at every clock edge outside reset.
`define TPGC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked at every clock edge, reset included.
`define TPGC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/tpgc_pkg.sv
// Types and constants of the two-player game clock.
package tpgc_pkg;

  // Request commands.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_START  = 1'b1;

  // Side to move.
  localparam logic SIDE_WHITE = 1'b0;
  localparam logic SIDE_BLACK = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_START_TIME = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INCREMENT  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE   = 2'd2;
  localparam int unsigned CFG_DATA_BITS = 32;

  // Configuration reset values.
  localparam logic [31:0] START_TIME_RESET = 32'd300000;
  localparam logic [31:0] INCREMENT_RESET  = 32'd0;
  localparam logic [15:0] DEBOUNCE_RESET   = 16'd50;

  localparam logic [31:0] MS_PER_SECOND = 32'd1000;

  // floor(t / 1000) = (t * MS_DIV_MAGIC) >> 38 for every 32-bit t.
  localparam logic [28:0] MS_DIV_MAGIC = 29'h1062_4DD3;
  localparam int unsigned MS_DIV_SHIFT = 38;
  // floor(s / 60) = (s * MIN_DIV_MAGIC) >> 37 for every 32-bit s.
  localparam logic [31:0] MIN_DIV_MAGIC = 32'h8888_8889;
  localparam int unsigned MIN_DIV_SHIFT = 37;

  localparam int unsigned SEC_BITS = 23;   // whole seconds of a 32-bit ms count
  localparam int unsigned MIN_BITS = 17;

  typedef struct packed {
    logic        command;
    logic [31:0] now_ms;
    logic        white_button;
    logic        black_button;
    logic        second_tick;
  } in_item_t;

  typedef struct packed {
    logic [31:0] white_time_ms;
    logic [31:0] black_time_ms;
    logic        active_side;
    logic [3:0]  led_bits;
    logic [16:0] white_minutes;
    logic [5:0]  white_secs;
    logic [16:0] black_minutes;
    logic [5:0]  black_secs;
    logic        white_changed;
    logic        black_changed;
  } out_item_t;

endpackage

### hw/rtl/two_player_game_clock.sv
// Two-player countdown game clock with Fischer increment, pipelined top level.
//
// This block is a chess clock with Fischer increment. A start request loads
// both clocks from start_time_ms, hands the move to white, clears the blink
// phase and forces both changed flags for the first result. Sample requests
// arriving before the first start leave the state alone and report it with
// both changed flags low. While the game runs, each sample request carries
// both active-low button levels, a wrapping millisecond timestamp and a
// one-second tick flag. A falling edge on a button counts when at least
// debounce_ms has passed since that button's last counted press; if it is the
// side to move, the increment is added to that clock (saturating at
// 2^TIME_BITS - 1) and the move passes. White is handled before black, so one
// request can pass the move twice. A tick then takes one second from the side
// to move, stopping at zero, and toggles the blink phase that drives the
// timeout LEDs. Every request yields exactly one result with both times, the
// side to move, the LEDs, minutes and seconds for each side, and flags that
// say whether the whole seconds of a side differ from what was last reported.
// The block takes one request per clock cycle while the output is not
// stalled. The rate is set by the game state update, which is a loop through
// the state registers: the debounce compare, the increment add and the
// one-second subtract finish in the cycle in which the request enters the
// state stage. The split into minutes and seconds follows in three more
// stages: the first two are each built around one constant reciprocal
// multiply per side, and the last forms the seconds within the minute and
// the changed flags in front of the output register. Every stage holds its
// request until the next one has room, so a stalled result does not block
// requests while empty stages remain.
// The user must write the configuration registers through the cfg port only
// while no request is in flight; the block itself does not enforce this.
module two_player_game_clock #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // Request channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  tpgc_pkg::in_item_t                      in_data,
  // Result channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output tpgc_pkg::out_item_t                     out_data,
  // Configuration write port
  input  logic                                    cfg_we,
  input  logic [tpgc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [tpgc_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  // Largest time the clocks can hold.
  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF >> (32 - TIME_BITS);

  // Configuration registers.
  logic [31:0] start_time_r;
  logic [31:0] increment_r;
  logic [15:0] debounce_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_time_r <= tpgc_pkg::START_TIME_RESET;
      increment_r  <= tpgc_pkg::INCREMENT_RESET;
      debounce_r   <= tpgc_pkg::DEBOUNCE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tpgc_pkg::CFG_START_TIME: start_time_r <= cfg_data;
        tpgc_pkg::CFG_INCREMENT:  increment_r  <= cfg_data;
        tpgc_pkg::CFG_DEBOUNCE:   debounce_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Stage occupancy and the ready chain. A stage can take a new request
  // when it is empty or when its own request moves on in the same cycle.
  logic v0_r, v1_r, v2_r, v3_r, v4_r;
  logic rdy0, rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_r || !out_stall;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign rdy0 = !v0_r || rdy1;

  assign in_stall = !rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Stage 0: input register.
  tpgc_pkg::in_item_t s0_r;

  always_ff @(posedge clk) begin
    if (rdy0) begin
      s0_r <= in_data;
    end
  end

  // Stage 1: the game state. The state registers double as the stage 1
  // payload, since they change only when the next request enters this stage.
  logic [TIME_BITS-1:0] white_rem_r, black_rem_r;
  logic                 side_r, blink_r, running_r;
  logic                 white_prev_r, black_prev_r;
  logic [31:0]          white_last_r, black_last_r;
  logic                 s1_start_r;

  logic [TIME_BITS-1:0] white_rem_nxt, black_rem_nxt;
  logic                 side_nxt, blink_nxt, running_nxt;
  logic                 white_prev_nxt, black_prev_nxt;
  logic [31:0]          white_last_nxt, black_last_nxt;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[31:0];
  endfunction

  function automatic logic [31:0] one_second_less(input logic [31:0] t);
    return (t >= tpgc_pkg::MS_PER_SECOND) ? t - tpgc_pkg::MS_PER_SECOND : 32'd0;
  endfunction

  always_comb begin
    logic [31:0] w_t, b_t, load_t;
    w_t            = 32'(white_rem_r);
    b_t            = 32'(black_rem_r);
    side_nxt       = side_r;
    blink_nxt      = blink_r;
    running_nxt    = running_r;
    white_prev_nxt = white_prev_r;
    black_prev_nxt = black_prev_r;
    white_last_nxt = white_last_r;
    black_last_nxt = black_last_r;
    load_t         = (start_time_r > TIME_MAX) ? TIME_MAX : start_time_r;

    if (s0_r.command == tpgc_pkg::CMD_START) begin
      w_t         = load_t;
      b_t         = load_t;
      side_nxt    = tpgc_pkg::SIDE_WHITE;
      blink_nxt   = 1'b0;
      running_nxt = 1'b1;
    end else if (running_r) begin
      // The elapsed time since the last press is a wrapping difference.
      if (white_prev_r && !s0_r.white_button &&
          (s0_r.now_ms - white_last_r) >= {16'd0, debounce_r}) begin
        white_last_nxt = s0_r.now_ms;
        if (side_nxt == tpgc_pkg::SIDE_WHITE) begin
          w_t      = sat_add(w_t, increment_r);
          side_nxt = tpgc_pkg::SIDE_BLACK;
        end
      end
      white_prev_nxt = s0_r.white_button;

      if (black_prev_r && !s0_r.black_button &&
          (s0_r.now_ms - black_last_r) >= {16'd0, debounce_r}) begin
        black_last_nxt = s0_r.now_ms;
        if (side_nxt == tpgc_pkg::SIDE_BLACK) begin
          b_t      = sat_add(b_t, increment_r);
          side_nxt = tpgc_pkg::SIDE_WHITE;
        end
      end
      black_prev_nxt = s0_r.black_button;

      if (s0_r.second_tick) begin
        if (side_nxt == tpgc_pkg::SIDE_WHITE) begin
          w_t = one_second_less(w_t);
        end else begin
          b_t = one_second_less(b_t);
        end
        blink_nxt = !blink_r;
      end
    end

    white_rem_nxt = TIME_BITS'(w_t);
    black_rem_nxt = TIME_BITS'(b_t);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_rem_r  <= '0;
      black_rem_r  <= '0;
      side_r       <= tpgc_pkg::SIDE_WHITE;
      blink_r      <= 1'b0;
      running_r    <= 1'b0;
      white_prev_r <= 1'b1;
      black_prev_r <= 1'b1;
      white_last_r <= '0;
      black_last_r <= '0;
    end else if (rdy1 && v0_r) begin
      white_rem_r  <= white_rem_nxt;
      black_rem_r  <= black_rem_nxt;
      side_r       <= side_nxt;
      blink_r      <= blink_nxt;
      running_r    <= running_nxt;
      white_prev_r <= white_prev_nxt;
      black_prev_r <= black_prev_nxt;
      white_last_r <= white_last_nxt;
      black_last_r <= black_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_start_r <= (s0_r.command == tpgc_pkg::CMD_START);
    end
  end

  // Stage 2: LEDs and whole seconds by reciprocal multiply.
  logic [31:0] white_t1, black_t1;
  logic [3:0]  leds1;
  logic [60:0] white_ms_prod, black_ms_prod;

  assign white_t1 = 32'(white_rem_r);
  assign black_t1 = 32'(black_rem_r);

  always_comb begin
    leds1    = 4'd0;
    leds1[0] = (side_r == tpgc_pkg::SIDE_WHITE) && (white_t1 != 32'd0);
    leds1[1] = (side_r == tpgc_pkg::SIDE_BLACK) && (black_t1 != 32'd0);
    leds1[2] = (white_t1 == 32'd0) && blink_r;
    leds1[3] = (black_t1 == 32'd0) && blink_r;
  end

  assign white_ms_prod = 61'(white_t1) * 61'(tpgc_pkg::MS_DIV_MAGIC);
  assign black_ms_prod = 61'(black_t1) * 61'(tpgc_pkg::MS_DIV_MAGIC);

  logic [31:0]                   s2_white_t_r, s2_black_t_r;
  logic                          s2_side_r, s2_start_r, s2_run_r;
  logic [3:0]                    s2_leds_r;
  logic [tpgc_pkg::SEC_BITS-1:0] s2_white_s_r, s2_black_s_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_white_t_r <= white_t1;
      s2_black_t_r <= black_t1;
      s2_side_r    <= side_r;
      s2_start_r   <= s1_start_r;
      s2_run_r     <= running_r;
      s2_leds_r    <= leds1;
      s2_white_s_r <= white_ms_prod[tpgc_pkg::MS_DIV_SHIFT +: tpgc_pkg::SEC_BITS];
      s2_black_s_r <= black_ms_prod[tpgc_pkg::MS_DIV_SHIFT +: tpgc_pkg::SEC_BITS];
    end
  end

  // Stage 3: whole minutes by reciprocal multiply.
  logic [54:0] white_min_prod, black_min_prod;

  assign white_min_prod = 55'(s2_white_s_r) * 55'(tpgc_pkg::MIN_DIV_MAGIC);
  assign black_min_prod = 55'(s2_black_s_r) * 55'(tpgc_pkg::MIN_DIV_MAGIC);

  logic [31:0]                   s3_white_t_r, s3_black_t_r;
  logic                          s3_side_r, s3_start_r, s3_run_r;
  logic [3:0]                    s3_leds_r;
  logic [tpgc_pkg::SEC_BITS-1:0] s3_white_s_r, s3_black_s_r;
  logic [tpgc_pkg::MIN_BITS-1:0] s3_white_m_r, s3_black_m_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_white_t_r <= s2_white_t_r;
      s3_black_t_r <= s2_black_t_r;
      s3_side_r    <= s2_side_r;
      s3_start_r   <= s2_start_r;
      s3_run_r     <= s2_run_r;
      s3_leds_r    <= s2_leds_r;
      s3_white_s_r <= s2_white_s_r;
      s3_black_s_r <= s2_black_s_r;
      s3_white_m_r <= white_min_prod[tpgc_pkg::MIN_DIV_SHIFT +: tpgc_pkg::MIN_BITS];
      s3_black_m_r <= black_min_prod[tpgc_pkg::MIN_DIV_SHIFT +: tpgc_pkg::MIN_BITS];
    end
  end

  // Stage 4: seconds within the minute, changed flags and output register.
  // With s = 60*m + r, r = s + 4*m modulo 64, and r is below 64, so only
  // the low bits of both values are needed.
  logic [5:0] white_r3, black_r3;
  logic       white_chg3, black_chg3;
  logic [tpgc_pkg::SEC_BITS-1:0] white_shown_r, black_shown_r;

  assign white_r3 = s3_white_s_r[5:0] + {s3_white_m_r[3:0], 2'b00};
  assign black_r3 = s3_black_s_r[5:0] + {s3_black_m_r[3:0], 2'b00};

  // A start always reports a change. While running, the shown seconds hold
  // the value of the previous running result, so inequality is a change.
  always_comb begin
    if (s3_start_r) begin
      white_chg3 = 1'b1;
      black_chg3 = 1'b1;
    end else if (s3_run_r) begin
      white_chg3 = (s3_white_s_r != white_shown_r);
      black_chg3 = (s3_black_s_r != black_shown_r);
    end else begin
      white_chg3 = 1'b0;
      black_chg3 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r && s3_run_r) begin
      white_shown_r <= s3_white_s_r;
      black_shown_r <= s3_black_s_r;
    end
  end

  tpgc_pkg::out_item_t out_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      out_r.white_time_ms <= s3_white_t_r;
      out_r.black_time_ms <= s3_black_t_r;
      out_r.active_side   <= s3_side_r;
      out_r.led_bits      <= s3_leds_r;
      out_r.white_minutes <= s3_white_m_r;
      out_r.white_secs    <= white_r3;
      out_r.black_minutes <= s3_black_m_r;
      out_r.black_secs    <= black_r3;
      out_r.white_changed <= white_chg3;
      out_r.black_changed <= black_chg3;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = out_r;

endmodule

### hw/rtl/tpgc_checker.sv
// Port-level checker for the two-player game clock and its bind.
`include "two_player_game_clock_macros.svh"

module tpgc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input tpgc_pkg::out_item_t out_data
);

  `TPGC_ASSERT(a_out_valid_held, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `TPGC_ASSERT(a_out_data_held, clk, rst_n, out_valid && out_stall |=> $stable(out_data), "stalled result changed")
  `TPGC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result shown right after reset")
  `TPGC_ASSERT(a_turn_led_side, clk, rst_n, out_valid |-> (!out_data.led_bits[0] || out_data.active_side == tpgc_pkg::SIDE_WHITE) && (!out_data.led_bits[1] || out_data.active_side == tpgc_pkg::SIDE_BLACK), "turn LED disagrees with side to move")
  `TPGC_ASSERT(a_secs_range, clk, rst_n, out_valid |-> (out_data.white_secs < 6'd60) && (out_data.black_secs < 6'd60), "seconds field out of range")

endmodule

bind two_player_game_clock tpgc_checker u_tpgc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
